FILE: hw/rtl/bcd_time_capture_lock_qualifier_macros.svh
// Assertion macros for the time capture lock qualifier.
`ifndef BCD_TIME_CAPTURE_LOCK_QUALIFIER_MACROS_SVH
`define BCD_TIME_CAPTURE_LOCK_QUALIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BCTCLQ_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BCTCLQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/bctclq_pkg.sv
// Types and constants shared by the time capture lock qualifier.
`default_nettype none

package bctclq_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned MS_W       = 11;
  localparam int unsigned TIME_W     = 8;
  localparam int unsigned DAY_W      = 11;
  localparam int unsigned YEAR_W     = 7;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned SOD_W      = 20;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_YEAR     = 1'b1;

  localparam logic [RUN_W-1:0]  LOCK_THRESHOLD_RST = 8'd10;
  localparam logic [YEAR_W-1:0] START_YEAR_RST     = 7'd0;

  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned MAX_HOUR     = 23;
  localparam int unsigned MAX_MIN_SEC  = 59;
  localparam int unsigned MAX_YEAR     = 99;

  typedef struct packed {
    logic [WORD_W-1:0] word_day_hundreds;
    logic [WORD_W-1:0] word_hour_day;
    logic [WORD_W-1:0] word_min_sec;
    logic [WORD_W-1:0] word_msec;
    logic              new_second;
  } snapshot_t;

  typedef struct packed {
    logic [MS_W-1:0]   millis;
    logic [TIME_W-1:0] seconds;
    logic [TIME_W-1:0] minutes;
    logic [TIME_W-1:0] hours;
    logic [DAY_W-1:0]  day_of_year;
    logic [SOD_W-1:0]  sec_of_day;
    logic              in_range;
  } decoded_t;

  typedef struct packed {
    logic [MS_W-1:0]   millis;
    logic [TIME_W-1:0] seconds;
    logic [TIME_W-1:0] minutes;
    logic [TIME_W-1:0] hours;
    logic [DAY_W-1:0]  day_of_year;
    logic [YEAR_W-1:0] year_now;
    logic              day_changed;
    logic              year_stepped;
    logic [RUN_W-1:0]  run_length;
    logic              locked;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bctclq_in_if.sv
// Snapshot channel: valid/ready plus the four raw time words and the new-second flag.
`default_nettype none

interface bctclq_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_day_hundreds;
  logic [15:0] word_hour_day;
  logic [15:0] word_min_sec;
  logic [15:0] word_msec;
  logic        new_second;

  modport source (
    output valid, word_day_hundreds, word_hour_day, word_min_sec, word_msec, new_second,
    input  ready
  );
  modport sink (
    input  valid, word_day_hundreds, word_hour_day, word_min_sec, word_msec, new_second,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/bctclq_out_if.sv
// Result channel: valid/ready plus decoded time, year and lock status.
`default_nettype none

interface bctclq_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] millis;
  logic [7:0]  seconds;
  logic [7:0]  minutes;
  logic [7:0]  hours;
  logic [10:0] day_of_year;
  logic [6:0]  year_now;
  logic        day_changed;
  logic        year_stepped;
  logic [7:0]  run_length;
  logic        locked;

  modport source (
    output valid, millis, seconds, minutes, hours, day_of_year, year_now,
           day_changed, year_stepped, run_length, locked,
    input  ready
  );
  modport sink (
    input  valid, millis, seconds, minutes, hours, day_of_year, year_now,
           day_changed, year_stepped, run_length, locked,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/bcd_time_capture_lock_qualifier.sv
// Top level: snapshot register, tracking state and result register.
//
// Takes one BCD time snapshot per clock and returns one result per snapshot, in
// order, while no result is held back by out_ch.ready; throughput is then one
// transaction per cycle. A snapshot passes an input register and then the result
// register. The day/year tracking and the valid-second run count are updated in
// the same cycle that moves a snapshot into the result register, so the next
// snapshot always sees the state left by the one before it. Config writes go
// straight into the registers; a write of start_year loads the tracked year,
// clamped to 99. Hold config writes to times when no transaction is in flight.
`default_nettype none

module bcd_time_capture_lock_qualifier (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  bctclq_in_if.sink                                      in_ch,
  bctclq_out_if.source                                   out_ch,
  input  wire logic                                      cfg_we,
  input  wire logic [bctclq_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  wire logic [bctclq_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

`include "bcd_time_capture_lock_qualifier_macros.svh"

  logic                                 in_v_r;
  bctclq_pkg::snapshot_t                snap_r;
  logic                                 out_v_r;
  bctclq_pkg::result_t                  out_r;
  bctclq_pkg::result_t                  out_nxt;

  logic [bctclq_pkg::RUN_W-1:0]         thr_r;
  logic [bctclq_pkg::DAY_W-1:0]         stored_day_r, stored_day_nxt;
  logic [bctclq_pkg::YEAR_W-1:0]        year_r, year_nxt;
  logic [bctclq_pkg::SOD_W-1:0]         prev_sod_r, prev_sod_nxt;
  logic [bctclq_pkg::RUN_W-1:0]         run_r, run_nxt;

  bctclq_pkg::decoded_t                 dec;
  logic                                 advance;
  logic                                 day_diff;
  logic                                 step;
  logic                                 sec_ok;
  logic [bctclq_pkg::YEAR_W-1:0]        year_inc;
  logic [bctclq_pkg::YEAR_W-1:0]        cfg_year;
  logic [bctclq_pkg::SOD_W:0]           prev_plus;

  bctclq_decode u_decode (
    .snap (snap_r),
    .dec  (dec)
  );

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  always_comb begin
    day_diff  = dec.day_of_year != stored_day_r;
    // a change to day one steps the year, except on the first day seen
    step      = day_diff && (stored_day_r != '0) && (dec.day_of_year == 11'd1);
    year_inc  = (year_r >= 7'(bctclq_pkg::MAX_YEAR)) ? '0 : year_r + 7'd1;
    cfg_year  = (cfg_wdata[bctclq_pkg::YEAR_W-1:0] > 7'(bctclq_pkg::MAX_YEAR))
              ? 7'(bctclq_pkg::MAX_YEAR) : cfg_wdata[bctclq_pkg::YEAR_W-1:0];
    prev_plus = {1'b0, prev_sod_r} + 21'd1;
    sec_ok    = ({1'b0, dec.sec_of_day} == prev_plus) && dec.in_range;

    stored_day_nxt = stored_day_r;
    year_nxt       = year_r;
    prev_sod_nxt   = prev_sod_r;
    run_nxt        = run_r;

    if (advance) begin
      if (day_diff) begin
        stored_day_nxt = dec.day_of_year;
      end
      if (step) begin
        year_nxt = year_inc;
      end
      if (snap_r.new_second) begin
        prev_sod_nxt = dec.sec_of_day;
        if (!sec_ok) begin
          run_nxt = '0;
        end else if (run_r < thr_r) begin
          run_nxt = run_r + 8'd1;
        end
      end
    end
    if (cfg_we && (cfg_idx == bctclq_pkg::REG_START_YEAR)) begin
      year_nxt = cfg_year;
    end

    out_nxt.millis       = dec.millis;
    out_nxt.seconds      = dec.seconds;
    out_nxt.minutes      = dec.minutes;
    out_nxt.hours        = dec.hours;
    out_nxt.day_of_year  = dec.day_of_year;
    out_nxt.year_now     = step ? year_inc : year_r;
    out_nxt.day_changed  = day_diff;
    out_nxt.year_stepped = step;
    out_nxt.run_length   = run_nxt;
    out_nxt.locked       = run_nxt >= thr_r;
  end

  // control and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      thr_r        <= bctclq_pkg::LOCK_THRESHOLD_RST;
      stored_day_r <= '0;
      year_r       <= bctclq_pkg::START_YEAR_RST;
      prev_sod_r   <= '0;
      run_r        <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we && (cfg_idx == bctclq_pkg::REG_LOCK_THRESHOLD)) begin
        thr_r <= cfg_wdata;
      end
      stored_day_r <= stored_day_nxt;
      year_r       <= year_nxt;
      prev_sod_r   <= prev_sod_nxt;
      run_r        <= run_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      snap_r.word_day_hundreds <= in_ch.word_day_hundreds;
      snap_r.word_hour_day     <= in_ch.word_hour_day;
      snap_r.word_min_sec      <= in_ch.word_min_sec;
      snap_r.word_msec         <= in_ch.word_msec;
      snap_r.new_second        <= in_ch.new_second;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.millis       = out_r.millis;
  assign out_ch.seconds      = out_r.seconds;
  assign out_ch.minutes      = out_r.minutes;
  assign out_ch.hours        = out_r.hours;
  assign out_ch.day_of_year  = out_r.day_of_year;
  assign out_ch.year_now     = out_r.year_now;
  assign out_ch.day_changed  = out_r.day_changed;
  assign out_ch.year_stepped = out_r.year_stepped;
  assign out_ch.run_length   = out_r.run_length;
  assign out_ch.locked       = out_r.locked;

  `BCTCLQ_ASSERT_NOW(a_stall_cause, !in_ch.ready, in_v_r && out_v_r && !out_ch.ready, "input stalled without a blocked result")
  `BCTCLQ_ASSERT_NEXT(a_advance_fills, advance, out_v_r, "transaction moved but no result is pending")
  `BCTCLQ_ASSERT_NOW(a_step_on_day_one, out_v_r && out_ch.year_stepped, out_ch.day_changed && (out_ch.day_of_year == 11'd1), "year stepped without a change to day one")
  `BCTCLQ_ASSERT_NEXT(a_run_holds, advance && !snap_r.new_second, $stable(run_r), "run count moved without a new second")

endmodule

`default_nettype wire

FILE: hw/rtl/bctclq_decode.sv
// BCD digit decode of one snapshot, seconds-of-day and range check.
`default_nettype none

module bctclq_decode (
  input  bctclq_pkg::snapshot_t snap,
  output bctclq_pkg::decoded_t  dec
);

  logic [3:0] ms_d1, ms_d2, ms_d3;
  logic [3:0] sec_d0, sec_d1, min_d0, min_d1;
  logic [3:0] hr_d0, hr_d1, day_d0, day_d1, day_d2;

  assign ms_d1  = snap.word_msec[7:4];
  assign ms_d2  = snap.word_msec[11:8];
  assign ms_d3  = snap.word_msec[15:12];
  assign sec_d0 = snap.word_min_sec[3:0];
  assign sec_d1 = snap.word_min_sec[7:4];
  assign min_d0 = snap.word_min_sec[11:8];
  assign min_d1 = snap.word_min_sec[15:12];
  assign hr_d0  = snap.word_hour_day[3:0];
  assign hr_d1  = snap.word_hour_day[7:4];
  assign day_d0 = snap.word_hour_day[11:8];
  assign day_d1 = snap.word_hour_day[15:12];
  assign day_d2 = snap.word_day_hundreds[3:0];

  // Digits are weighted as they stand; out-of-range digits are not rejected.
  always_comb begin
    dec.millis      = 11'(ms_d1) + 11'(ms_d2) * 11'd10 + 11'(ms_d3) * 11'd100;
    dec.seconds     = 8'(sec_d0) + 8'(sec_d1) * 8'd10;
    dec.minutes     = 8'(min_d0) + 8'(min_d1) * 8'd10;
    dec.hours       = 8'(hr_d0) + 8'(hr_d1) * 8'd10;
    dec.day_of_year = 11'(day_d0) + 11'(day_d1) * 11'd10 + 11'(day_d2) * 11'd100;
    dec.sec_of_day  = 20'(dec.hours) * 20'(bctclq_pkg::SEC_PER_HOUR)
                    + 20'(dec.minutes) * 20'(bctclq_pkg::SEC_PER_MIN)
                    + 20'(dec.seconds);
    dec.in_range    = (dec.hours <= 8'(bctclq_pkg::MAX_HOUR))
                   && (dec.minutes <= 8'(bctclq_pkg::MAX_MIN_SEC))
                   && (dec.seconds <= 8'(bctclq_pkg::MAX_MIN_SEC));
  end

endmodule

`default_nettype wire
